// File: rtl/cdad_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date add days: shared package
// Payload types, status codes, controller/datapath signal groups and the
// calendar tables used by the datapath.
// ----------------------------------------------------------------------------
package cdad_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_MONTH = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // Calendar constants.
   localparam logic [14:0] YEAR_MAX       = 15'd32767;
   localparam logic [3:0]  MONTH_JAN      = 4'd1;
   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_DEC      = 4'd12;
   localparam logic [4:0]  DAYS_LONG      = 5'd31;
   localparam logic [4:0]  DAYS_SHORT     = 5'd30;
   localparam logic [4:0]  DAYS_FEB       = 5'd28;
   localparam logic [4:0]  DAYS_FEB_LEAP  = 5'd29;
   localparam logic [8:0]  DAYS_YEAR      = 9'd365;
   localparam logic [8:0]  DAYS_YEAR_LEAP = 9'd366;

   // Reciprocal of 25: floor(year * 5243 / 2^17) equals year / 25 for all
   // 15-bit years.
   localparam logic [12:0] RECIP_25       = 13'd5243;
   localparam int          RECIP_SHIFT    = 17;

   // Input beat.
   typedef struct packed {
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [14:0] start_year;
      logic [14:0] days_to_add;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [4:0]  end_day;
      logic [3:0]  end_month;
      logic [14:0] end_year;
      logic [1:0]  status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       calc_quot;
      logic       calc_mod;
      logic       calc_sum;
      logic       year_step;
      logic       month_step;
      logic       set_status;
      logic [1:0] status_code;
      logic       out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic month_bad;
      logic year_more;
      logic year_at_max;
      logic month_more;
      logic out_free;
   } sts_type;

   // Length of a month, 1 to 12.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = DAYS_SHORT;
         MONTH_FEB:               len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         default:                 len = DAYS_LONG;
      endcase
      return len;
   endfunction

   // Days in the months before the given month.
   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] base;
      unique case (month)
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (month > MONTH_FEB)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// File: rtl/cdad_dpath.sv
// ----------------------------------------------------------------------------
// Calendar date add days: datapath
// Holds the item, the running day count, year, month and the year's
// remainder modulo 25, and the output register of the result channel.
// ----------------------------------------------------------------------------
module cdad_dpath import cdad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [14:0] year_ff, year_in;
   logic [14:0] add_ff, add_in;
   logic [10:0] quot_ff, quot_in;
   logic [4:0]  mod25_ff, mod25_in;
   logic [15:0] rem_ff, rem_in;
   logic [3:0]  mon_ff, mon_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [27:0] prod;
   logic [15:0] quot_x25;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;

   // Leap rule from the low year bits and the remainder modulo 25.
   assign leap = ((year_ff[1:0] == 2'd0) && (mod25_ff != 5'd0)) ||
                 ((year_ff[3:0] == 4'd0) && (mod25_ff == 5'd0));
   assign year_len = leap ? DAYS_YEAR_LEAP : DAYS_YEAR;
   assign mon_len  = month_days(mon_ff, leap);

   // Quotient by 25 through the reciprocal, and its multiple back.
   assign prod     = {13'd0, year_ff} * {15'd0, RECIP_25};
   assign quot_x25 = {1'b0, quot_ff, 4'd0} + {2'b0, quot_ff, 3'd0} + {5'd0, quot_ff};

   // Status towards the controller.
   assign sts.month_bad   = (month_ff == 4'd0) || (month_ff > MONTH_DEC);
   assign sts.year_more   = {7'd0, year_len} < rem_ff;
   assign sts.year_at_max = year_ff == YEAR_MAX;
   assign sts.month_more  = ({11'd0, mon_len} < rem_ff) && (mon_ff != MONTH_DEC);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   // Working registers.
   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      add_in    = add_ff;
      quot_in   = quot_ff;
      mod25_in  = mod25_ff;
      rem_in    = rem_ff;
      mon_in    = mon_ff;
      status_in = status_ff;
      if (cmd.load) begin
         day_in   = req_data.start_day;
         month_in = req_data.start_month;
         year_in  = req_data.start_year;
         add_in   = req_data.days_to_add;
      end
      if (cmd.calc_quot) begin
         quot_in = prod[RECIP_SHIFT +: 11];
      end
      if (cmd.calc_mod) begin
         mod25_in = 5'(({1'b0, year_ff} - quot_x25));
      end
      if (cmd.calc_sum) begin
         rem_in = {11'd0, day_ff} + {7'd0, days_before(month_ff, leap)} + {1'b0, add_ff};
         mon_in = MONTH_JAN;
      end
      if (cmd.year_step) begin
         rem_in   = rem_ff - {7'd0, year_len};
         year_in  = year_ff + 15'd1;
         mod25_in = (mod25_ff == 5'd24) ? 5'd0 : mod25_ff + 5'd1;
      end
      if (cmd.month_step) begin
         rem_in = rem_ff - {11'd0, mon_len};
         mon_in = mon_ff + 4'd1;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
   end

   always_ff @(posedge clock) begin
      day_ff    <= day_in;
      month_ff  <= month_in;
      year_ff   <= year_in;
      add_ff    <= add_in;
      quot_ff   <= quot_in;
      mod25_ff  <= mod25_in;
      rem_ff    <= rem_in;
      mon_ff    <= mon_in;
      status_ff <= status_in;
   end

   // Result beat, chosen by the final status.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         case (status_ff)
            STATUS_BAD_MONTH: begin
               rsp_data_in.end_day   = 5'd0;
               rsp_data_in.end_month = MONTH_JAN;
               rsp_data_in.end_year  = 15'd0;
               rsp_data_in.status    = STATUS_BAD_MONTH;
            end
            STATUS_OVERFLOW: begin
               rsp_data_in.end_day   = DAYS_LONG;
               rsp_data_in.end_month = MONTH_DEC;
               rsp_data_in.end_year  = YEAR_MAX;
               rsp_data_in.status    = STATUS_OVERFLOW;
            end
            default: begin
               rsp_data_in.end_day   = rem_ff[4:0];
               rsp_data_in.end_month = mon_ff;
               rsp_data_in.end_year  = year_ff;
               rsp_data_in.status    = STATUS_OK;
            end
         endcase
      end
   end

   // Output register valid: set on load, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/cdad_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date add days: controller
// Sequences one item through month check, modulo setup, day-of-year sum,
// the year walk, the month walk and the hand-off to the output register.
// ----------------------------------------------------------------------------
module cdad_ctrl import cdad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_QUOT  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_YEAR  = 3'd4;
   localparam logic [2:0] S_MONTH = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   // The block takes a new beat only between items.
   assign req_stall = state_ff != S_IDLE;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            if (sts.month_bad) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_BAD_MONTH;
               state_in        = S_DONE;
            end else begin
               cmd.calc_quot = 1'b1;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            cmd.calc_mod = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.calc_sum    = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_OK;
            state_in        = S_YEAR;
         end
         S_YEAR: begin
            if (sts.year_more) begin
               if (sts.year_at_max) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_OVERFLOW;
                  state_in        = S_DONE;
               end else begin
                  cmd.year_step = 1'b1;
               end
            end else begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (sts.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/calendar_date_add_days_top.sv
// ----------------------------------------------------------------------------
// Calendar date add days: top level
// Adds a day count to a Gregorian date and reports the resulting date.
// ----------------------------------------------------------------------------
// One item is worked on at a time: the month check, the modulo setup and the
// day-of-year sum come first, then one step for each whole year crossed and
// one for each month stepped (up to 11), then the hand-off to the output
// register. The walk over years, one year per cycle through a single
// subtractor, is the longest part of an item. A stall on the result channel
// that still holds the previous result when the walk ends delays the hand-off.
// The result waits in an output register, so the next beat is taken as soon
// as the previous result has been written there. A start month outside 1 to
// 12 gives status 1, and a year carried beyond 32767 saturates to
// 31 December 32767 with status 2.
module calendar_date_add_days_top import cdad_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   cdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic and output register.
   cdad_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // An accepted beat closes the input until its result is written to the output register.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted beat");

   // The year and month walks never step together.
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      !(cmd.year_step && cmd.month_step))
      else $error("year and month step in the same cycle");

   // A saturated result always lies in December of the last year.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_OVERFLOW)) |->
      ((rsp_data.end_year == YEAR_MAX) && (rsp_data.end_month == MONTH_DEC)))
      else $error("overflow status without saturated date");

   // Every result has a month from 1 to 12 and a known status.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.end_month >= MONTH_JAN) &&
                     (rsp_data.end_month <= MONTH_DEC) &&
                     (rsp_data.status <= STATUS_OVERFLOW)))
      else $error("result month or status out of range");
`endif

endmodule

// File: verif/tb_calendar_date_add_days_top.sv
// ----------------------------------------------------------------------------
// Calendar date add days: testbench
// Sends date beats through the valid/stall request channel and checks every
// result beat against a date predictor kept in the bench. Directed tests
// cover each month, the calendar edge cases and year saturation. Random tests
// follow, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb_calendar_date_add_days_top;
   import cdad_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 150;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Predicted result beats, oldest first.
   rsp_type pending_dates[$];
   int      mismatch_count;
   int      quiet_cycles;
   bit      send_idle_on;
   bit      rsp_idle_on;

   calendar_date_add_days_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with a period of 8 time units.
   always #4 clock = ~clock;

   // Gregorian leap rule; year 0 is divisible by 400 and so counts as leap.
   function automatic bit is_leap_year(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned month,
                                                input int unsigned year);
      int unsigned len;
      case (month)
         4, 6, 9, 11: len = DAYS_SHORT;
         2:           len = is_leap_year(year) ? DAYS_FEB_LEAP : DAYS_FEB;
         default:     len = DAYS_LONG;
      endcase
      return len;
   endfunction

   function automatic int unsigned year_length(input int unsigned year);
      return is_leap_year(year) ? DAYS_YEAR_LEAP : DAYS_YEAR;
   endfunction

   // Works out the date reached by adding the day count to the start date.
   function automatic rsp_type predict_date(input req_type item);
      rsp_type     res;
      int unsigned year;
      int unsigned remaining;
      int unsigned month;
      res.end_day   = '0;
      res.end_month = MONTH_JAN;
      res.end_year  = '0;
      res.status    = STATUS_BAD_MONTH;
      if (item.start_month < MONTH_JAN || item.start_month > MONTH_DEC) begin
         return res;
      end
      year = item.start_year;
      remaining = item.start_day;
      for (month = 1; month < item.start_month; month++) begin
         remaining += month_length(month, year);
      end
      remaining += item.days_to_add;
      // Whole years first; a carry past the last year saturates.
      while (remaining > year_length(year)) begin
         if (year >= YEAR_MAX) begin
            res.end_day   = DAYS_LONG;
            res.end_month = MONTH_DEC;
            res.end_year  = YEAR_MAX;
            res.status    = STATUS_OVERFLOW;
            return res;
         end
         remaining -= year_length(year);
         year++;
      end
      // Then whole months from January.
      month = 1;
      while (month < MONTH_DEC && remaining > month_length(month, year)) begin
         remaining -= month_length(month, year);
         month++;
      end
      res.end_day   = 5'(remaining);
      res.end_month = 4'(month);
      res.end_year  = 15'(year);
      res.status    = STATUS_OK;
      return res;
   endfunction

   function automatic req_type make_date(input int unsigned day, input int unsigned month,
                                         input int unsigned year, input int unsigned add);
      req_type item;
      item.start_day   = 5'(day);
      item.start_month = 4'(month);
      item.start_year  = 15'(year);
      item.days_to_add = 15'(add);
      return item;
   endfunction

   // A random start date. Well-formed dates have a month in range and a day
   // within that month; the rest take any value the fields allow.
   function automatic req_type random_date(input bit well_formed);
      int unsigned day;
      int unsigned month;
      int unsigned year;
      int unsigned add;
      case ($urandom_range(0, 3))
         0:       year = $urandom_range(0, 32767);
         1:       year = $urandom_range(32600, 32767);
         2:       year = $urandom_range(0, 2100);
         default: year = 400 * $urandom_range(0, 80) + 100 * $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 2))
         0:       add = $urandom_range(0, 32767);
         1:       add = $urandom_range(0, 400);
         default: add = $urandom_range(32000, 32767);
      endcase
      if (well_formed) begin
         month = $urandom_range(1, 12);
         day   = $urandom_range(1, month_length(month, year));
      end else begin
         month = $urandom_range(0, 15);
         day   = $urandom_range(0, 31);
      end
      return make_date(day, month, year, add);
   endfunction

   // Sends one beat and records its predicted result once it is accepted.
   task automatic send_date(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_dates.push_back(predict_date(item));
      // An occasional gap before the next beat.
      if (send_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected day %0d month %0d year %0d status %0d",
                  what, want.end_day, want.end_month, want.end_year, want.status);
         $display("   got day %0d month %0d year %0d status %0d",
                  got.end_day, got.end_month, got.end_year, got.status);
      end
   endtask

   // Every month with an ordinary start, then start months out of range.
   task automatic test_month_table();
      for (int m = 1; m <= 12; m++) begin
         send_date(make_date(1, m, 2023, 0));
      end
      send_date(make_date(15, 0, 2000, 10));
      send_date(make_date(1, 13, 1999, 0));
      send_date(make_date(31, 15, 32767, 32767));
   endtask

   task automatic test_calendar_edges();
      // Zero day on January 1 with nothing added.
      send_date(make_date(0, 1, 2024, 0));
      // Oversized day rolls into the following months.
      send_date(make_date(31, 2, 2023, 0));
      // Leap day: year 0, a plain century, a 400-year century, an ordinary leap year.
      send_date(make_date(28, 2, 0, 1));
      send_date(make_date(28, 2, 1900, 1));
      send_date(make_date(28, 2, 2000, 1));
      send_date(make_date(28, 2, 2024, 1));
      // Field extremes, with and without year saturation.
      send_date(make_date(0, 1, 0, 0));
      send_date(make_date(1, 1, 0, 32767));
      send_date(make_date(31, 12, 32767, 0));
      send_date(make_date(31, 12, 32767, 1));
      send_date(make_date(1, 1, 32767, 32767));
      send_date(make_date(31, 12, 32766, 32767));
   endtask

   // Mostly well-formed dates with some noise; idling switches on and off
   // in stretches of 50 beats, and the sender drains now and then.
   task automatic test_random_dates();
      for (int n = 0; n < 700; n++) begin
         if (n % 50 == 0) begin
            send_idle_on = (n / 50) % 3 != 2;
            rsp_idle_on  = (n / 50) % 3 != 2;
         end
         if (n % 97 == 96) begin
            wait_for_drain();
         end
         send_date(random_date($urandom_range(0, 9) != 0));
      end
   endtask

   // Each beat sent only once every earlier result has arrived.
   task automatic test_drained_sends();
      for (int n = 0; n < 10; n++) begin
         wait_for_drain();
         send_date(random_date(1'b1));
      end
   endtask

   // A closing stream with no idling on either side.
   task automatic test_unbroken_stream();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      for (int n = 0; n < 150; n++) begin
         send_date(random_date($urandom_range(0, 9) != 0));
      end
   endtask

   // Result channel: occasional bursts of stall.
   always begin
      @(posedge clock);
      if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 11)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Compares each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            want = '0;
            note_mismatch("unexpected result beat", want, rsp_data);
         end else begin
            want = pending_dates.pop_front();
            if (rsp_data.end_day !== want.end_day || rsp_data.end_month !== want.end_month ||
                rsp_data.end_year !== want.end_year || rsp_data.status !== want.status) begin
               note_mismatch("wrong result beat", want, rsp_data);
            end
         end
      end
   end

   // Ends the run if nothing is accepted on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("calendar_date_add_days_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      send_idle_on   = 1'b1;
      rsp_idle_on    = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_month_table();
      test_calendar_edges();
      test_random_dates();
      test_drained_sends();
      test_unbroken_stream();

      // Let the last results arrive, then allow for the block's latency.
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_dates.size() == 0) begin
         $display("calendar_date_add_days_top: match");
      end else begin
         $display("calendar_date_add_days_top: mismatch");
      end
      $finish;
   end

endmodule
